[hdl/lru_age_counter_cache_directory_unit_macros.svh]
// assertion macros for the cache directory
`ifndef LRU_AGE_COUNTER_CACHE_DIRECTORY_UNIT_MACROS_SVH
`define LRU_AGE_COUNTER_CACHE_DIRECTORY_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define LACD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lacd assertion failed");
// next-cycle implication, disabled in reset
`define LACD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lacd assertion failed");
`else
`define LACD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LACD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/lacd_pkg.sv]
package lacd_pkg;

    // directory geometry
    localparam int ENTRIES    = 16;
    localparam int MAX_LENGTH = 102400;
    localparam int INDEX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LEAVES     = 1 << INDEX_W;

    // field widths
    localparam int KEY_W = 64;
    localparam int LEN_W = 17;
    localparam int WAY_W = 4;
    localparam int AGE_W = 32;

    typedef logic [INDEX_W-1:0] t_idx;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [WAY_W-1:0]   t_way;
    typedef logic [AGE_W-1:0]   t_age;

    // operation codes
    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } t_cmd;

    // node of the oldest-entry search tree
    typedef struct packed {
        t_idx idx;
        t_age age;
    } t_node;

    // older of two nodes, ties to the left (lower index)
    function automatic t_node older_node(input t_node a, input t_node b);
        t_node r;
        r = (b.age > a.age) ? b : a;
        return r;
    endfunction

endpackage

[hdl/lru_age_counter_cache_directory_unit.sv]
// a word accepted into the input register moves on to the result register and o_valid when that stage is free or drains
// throughput: one word per cycle while i_ready stays high; lookup, victim pick and age update are combinational
// the age search is a combinational compare tree over all entries
// reset (i_rst_n low, synchronous): all entries invalid, ages zero, both stages empty
// keys and lengths are not reset; they are read only from valid entries
`include "lru_age_counter_cache_directory_unit_macros.svh"

module lru_age_counter_cache_directory_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  lacd_pkg::t_key        i_key,
    input  lacd_pkg::t_len        i_object_length,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_hit,
    output lacd_pkg::t_way        o_way,
    output lacd_pkg::t_len        o_stored_length,
    output logic                  o_evicted
);

    // directory state
    logic [lacd_pkg::ENTRIES-1:0] r_entry_valid;
    lacd_pkg::t_key               r_entry_key    [lacd_pkg::ENTRIES];
    lacd_pkg::t_len               r_entry_length [lacd_pkg::ENTRIES];
    lacd_pkg::t_age               r_entry_age    [lacd_pkg::ENTRIES];

    // input stage
    logic                         r_in_valid;
    lacd_pkg::t_cmd               r_in_cmd;
    lacd_pkg::t_key               r_in_key;
    lacd_pkg::t_len               r_in_len;

    // result stage
    logic                         r_out_valid;
    logic                         r_out_hit;
    lacd_pkg::t_way               r_out_way;
    lacd_pkg::t_len               r_out_len;
    logic                         r_out_evicted;

    logic                         w_move;
    logic                         w_insert;
    logic                         w_hit;
    lacd_pkg::t_idx               w_hit_idx;
    logic                         w_any_free;
    lacd_pkg::t_idx               w_free_idx;
    lacd_pkg::t_node              w_oldest;
    lacd_pkg::t_idx               w_slot;
    logic                         w_evicted;
    logic                         w_touch;
    lacd_pkg::t_len               w_len_clamped;
    lacd_pkg::t_node              w_tree [lacd_pkg::INDEX_W+1][lacd_pkg::LEAVES];

    // handshake: the input word moves on when the result stage is free or drains
    assign w_move   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || w_move;
    assign w_insert = (r_in_cmd == lacd_pkg::CMD_INSERT);

    // key match, lowest matching entry wins
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = lacd_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (r_entry_valid[i] && (r_entry_key[i] == r_in_key)) begin
                w_hit     = 1'b1;
                w_hit_idx = lacd_pkg::t_idx'(i);
            end
        end
    end

    // lowest free entry
    always_comb begin
        w_any_free = 1'b0;
        w_free_idx = '0;
        for (int i = lacd_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!r_entry_valid[i]) begin
                w_any_free = 1'b1;
                w_free_idx = lacd_pkg::t_idx'(i);
            end
        end
    end

    // oldest entry, ties and all-zero ages go to the lowest index
    always_comb begin
        for (int l = 0; l <= lacd_pkg::INDEX_W; l++) begin
            for (int i = 0; i < lacd_pkg::LEAVES; i++) begin
                w_tree[l][i] = '0;
            end
        end
        for (int i = 0; i < lacd_pkg::LEAVES; i++) begin
            w_tree[0][i].idx = lacd_pkg::t_idx'(i);
            w_tree[0][i].age = (i < lacd_pkg::ENTRIES) ? r_entry_age[i] : '0;
        end
        for (int l = 0; l < lacd_pkg::INDEX_W; l++) begin
            for (int j = 0; j < (lacd_pkg::LEAVES >> (l + 1)); j++) begin
                w_tree[l+1][j] = lacd_pkg::older_node(w_tree[l][2*j], w_tree[l][2*j+1]);
            end
        end
        w_oldest = w_tree[lacd_pkg::INDEX_W][0];
    end

    // slot choice and length clamp
    assign w_slot    = w_insert ? (w_any_free ? w_free_idx : w_oldest.idx) : w_hit_idx;
    assign w_evicted = w_insert && !w_any_free;
    assign w_touch   = w_move && (w_insert || w_hit);
    assign w_len_clamped = (r_in_len > lacd_pkg::t_len'(lacd_pkg::MAX_LENGTH))
                         ? lacd_pkg::t_len'(lacd_pkg::MAX_LENGTH) : r_in_len;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_cmd <= lacd_pkg::t_cmd'(i_cmd);
            r_in_key <= i_key;
            r_in_len <= i_object_length;
        end
    end

    // valid bits and ages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            for (int i = 0; i < lacd_pkg::ENTRIES; i++) begin
                r_entry_age[i] <= '0;
            end
        end else if (w_touch) begin
            if (w_insert) begin
                r_entry_valid[w_slot] <= 1'b1;
            end
            for (int i = 0; i < lacd_pkg::ENTRIES; i++) begin
                if (lacd_pkg::t_idx'(i) == w_slot) begin
                    r_entry_age[i] <= '0;
                end else if (r_entry_valid[i] && (r_entry_age[i] != '1)) begin
                    r_entry_age[i] <= r_entry_age[i] + 1'b1;
                end
            end
        end
    end

    // key and length store
    always_ff @(posedge i_clk) begin
        if (w_move && w_insert) begin
            r_entry_key[w_slot]    <= r_in_key;
            r_entry_length[w_slot] <= w_len_clamped;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_move) begin
            r_out_hit     <= !w_insert && w_hit;
            r_out_way     <= (w_insert || w_hit) ? lacd_pkg::t_way'(w_slot) : '0;
            r_out_len     <= (!w_insert && w_hit) ? r_entry_length[w_hit_idx] : '0;
            r_out_evicted <= w_evicted;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_way           = r_out_way;
    assign o_stored_length = r_out_len;
    assign o_evicted       = r_out_evicted;

    // checks
    `LACD_ASSERT_IMPL(a_evict_only_when_full, i_clk, i_rst_n, w_move && w_evicted, &r_entry_valid)
    `LACD_ASSERT_NEXT(a_touched_entry_fresh, i_clk, i_rst_n, w_touch, r_entry_valid[$past(w_slot)] && (r_entry_age[$past(w_slot)] == '0))
    `LACD_ASSERT_IMPL(a_hit_not_evict, i_clk, i_rst_n, o_valid, !(o_hit && o_evicted))
    `LACD_ASSERT_IMPL(a_miss_zero_length, i_clk, i_rst_n, o_valid && !o_hit, o_stored_length == '0)

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import lacd_pkg::*;

    localparam int RANDOM_WORDS = 1400;
    localparam int PHASE_WORDS  = 467;
    localparam int DIRECTED_CNT = 25;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_AT      = 1100;
    localparam int HOLD_CYCLES  = 120;
    localparam int CYCLE_LIMIT  = 200000;

    // one result word of the directory
    typedef struct packed {
        logic hit;
        t_way way;
        t_len stored_length;
        logic evicted;
    } dir_result_t;

    // one row of the directed stimulus table
    typedef struct packed {
        t_cmd        cmd;
        t_key        key;
        t_len        length;
        logic        known;
        dir_result_t result;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_cmd = 1'b0;
    t_key i_key = '0;
    t_len i_object_length = '0;
    logic i_ready = 1'b0;
    logic o_ready;
    logic o_valid;
    logic o_hit;
    t_way o_way;
    t_len o_stored_length;
    logic o_evicted;

    // shadow copy of the directory
    logic model_valid [ENTRIES];
    t_key model_key [ENTRIES];
    t_len model_len [ENTRIES];
    t_age model_age [ENTRIES];

    dir_result_t pending_results [$];
    dir_result_t expected_result;
    int send_idle_pct = 36;
    int recv_idle_pct = 68;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit failed = 1'b0;
    int cycle_count = 0;

    // directed words: extremes, oversized length, duplicate insert, fill and evict
    dir_row_t directed_rows [DIRECTED_CNT] = '{
        '{CMD_LOOKUP, 64'h0, 17'd0, 1'b1, '{1'b0, 4'd0, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'h0, 17'd0, 1'b1, '{1'b0, 4'd0, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 17'd102400, 1'b1,
          '{1'b0, 4'd1, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'h8000_0000_0000_0001, 17'd131071, 1'b1,
          '{1'b0, 4'd2, 17'd0, 1'b0}},
        '{CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 17'd131071, 1'b1,
          '{1'b1, 4'd1, 17'd102400, 1'b0}},
        '{CMD_LOOKUP, 64'h8000_0000_0000_0001, 17'd0, 1'b1,
          '{1'b1, 4'd2, 17'd102400, 1'b0}},
        '{CMD_LOOKUP, 64'h0, 17'd0, 1'b1, '{1'b1, 4'd0, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 17'd1, 1'b1, '{1'b0, 4'd3, 17'd0, 1'b0}},
        '{CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 17'd0, 1'b1,
          '{1'b1, 4'd1, 17'd102400, 1'b0}},
        '{CMD_INSERT, 64'hA5A5_0000_0000_0004, 17'd4000, 1'b1, '{1'b0, 4'd4, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hA5A5_0000_0000_0005, 17'd5000, 1'b1, '{1'b0, 4'd5, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hA5A5_0000_0000_0006, 17'd6000, 1'b1, '{1'b0, 4'd6, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hA5A5_0000_0000_0007, 17'd7000, 1'b1, '{1'b0, 4'd7, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hA5A5_0000_0000_0008, 17'd8000, 1'b1, '{1'b0, 4'd8, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hA5A5_0000_0000_0009, 17'd9000, 1'b1, '{1'b0, 4'd9, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hA5A5_0000_0000_000A, 17'd10000, 1'b1,
          '{1'b0, 4'd10, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hA5A5_0000_0000_000B, 17'd11000, 1'b1,
          '{1'b0, 4'd11, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hA5A5_0000_0000_000C, 17'd12000, 1'b1,
          '{1'b0, 4'd12, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hA5A5_0000_0000_000D, 17'd13000, 1'b1,
          '{1'b0, 4'd13, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hA5A5_0000_0000_000E, 17'd14000, 1'b1,
          '{1'b0, 4'd14, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'hA5A5_0000_0000_000F, 17'd15000, 1'b1,
          '{1'b0, 4'd15, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 17'd77, 1'b0, '0},
        '{CMD_LOOKUP, 64'h0123_4567_89AB_CDEF, 17'd0, 1'b1, '{1'b0, 4'd0, 17'd0, 1'b0}},
        '{CMD_INSERT, 64'h0F0F_0F0F_0F0F_0F0F, 17'd102401, 1'b0, '0},
        '{CMD_LOOKUP, 64'h5A5A_5A5A_5A5A_5A5A, 17'd0, 1'b0, '0}
    };

    lru_age_counter_cache_directory_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_key           (i_key),
        .i_object_length (i_object_length),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_way           (o_way),
        .o_stored_length (o_stored_length),
        .o_evicted       (o_evicted)
    );

    always #6 i_clk = ~i_clk;

    // age every valid entry, saturating, then clear the touched one
    function automatic void age_and_touch(int slot);
        for (int i = 0; i < ENTRIES; i++) begin
            if (model_valid[i] && model_age[i] != '1)
                model_age[i] = model_age[i] + 1'b1;
        end
        if (model_valid[slot])
            model_age[slot] = '0;
    endfunction

    // apply one request word to the shadow directory and return its result
    function automatic dir_result_t predict_directory(t_cmd cmd, t_key key, t_len length);
        dir_result_t r;
        int slot;
        t_age oldest;
        r = '0;
        slot = -1;
        if (cmd == CMD_LOOKUP) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot < 0 && model_valid[i] && model_key[i] == key)
                    slot = i;
            end
            if (slot >= 0) begin
                r.hit = 1'b1;
                r.way = t_way'(slot);
                r.stored_length = model_len[slot];
                age_and_touch(slot);
            end
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot < 0 && !model_valid[i])
                    slot = i;
            end
            // full: oldest entry, ties to the lowest number
            if (slot < 0) begin
                slot = 0;
                oldest = '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (model_age[i] > oldest) begin
                        oldest = model_age[i];
                        slot = i;
                    end
                end
                r.evicted = 1'b1;
            end
            model_key[slot] = key;
            model_len[slot] = (length > MAX_LENGTH) ? t_len'(MAX_LENGTH) : length;
            model_age[slot] = '0;
            model_valid[slot] = 1'b1;
            age_and_touch(slot);
            r.way = t_way'(slot);
        end
        return r;
    endfunction

    // offer one request word and record its expected result once accepted
    task automatic send_word(t_cmd cmd, t_key key, t_len length, logic known,
                             dir_result_t known_result);
        dir_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_key <= key;
        i_object_length <= length;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predicted = predict_directory(cmd, key, length);
        pending_results.push_back(known ? known_result : predicted);
    endtask

    // result side: check accepted words, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no request pending");
                failed = 1'b1;
            end else begin
                expected_result = pending_results.pop_front();
                if (o_hit !== expected_result.hit) begin
                    $error("hit: expected %0d, actual %0d", expected_result.hit, o_hit);
                    failed = 1'b1;
                end
                if (o_way !== expected_result.way) begin
                    $error("way: expected %0d, actual %0d", expected_result.way, o_way);
                    failed = 1'b1;
                end
                if (o_stored_length !== expected_result.stored_length) begin
                    $error("stored_length: expected %0d, actual %0d",
                           expected_result.stored_length, o_stored_length);
                    failed = 1'b1;
                end
                if (o_evicted !== expected_result.evicted) begin
                    $error("evicted: expected %0d, actual %0d",
                           expected_result.evicted, o_evicted);
                    failed = 1'b1;
                end
                results_seen++;
            end
        end
        // one long hold-off so the block backs up into its input
        if (hold_left == 0 && !hold_done && results_seen >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // stimulus
    initial begin
        t_cmd cmd;
        t_key key;
        t_len length;
        int pick;
        int slot;
        t_key key_pool [POOL_SIZE];

        for (int i = 0; i < ENTRIES; i++) begin
            model_valid[i] = 1'b0;
            model_key[i] = '0;
            model_len[i] = '0;
            model_age[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIRECTED_CNT; r++) begin
            send_word(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].length,
                      directed_rows[r].known, directed_rows[r].result);
        end

        // random traffic over a reused key pool so lookups hit and inserts evict
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == PHASE_WORDS) begin
                send_idle_pct = 68;
                recv_idle_pct = 36;
            end else if (n == 2 * PHASE_WORDS) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(19) == 0)
                key_pool[$urandom_range(POOL_SIZE - 1)] = {$urandom, $urandom};
            cmd = t_cmd'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 50) begin
                slot = $urandom_range(ENTRIES - 1);
                key = model_valid[slot] ? model_key[slot]
                                        : key_pool[$urandom_range(POOL_SIZE - 1)];
            end else if (pick < 85) begin
                key = key_pool[$urandom_range(POOL_SIZE - 1)];
            end else begin
                key = {$urandom, $urandom};
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                length = t_len'($urandom_range(MAX_LENGTH));
            end else if (pick < 85) begin
                case ($urandom_range(3))
                    0: length = '0;
                    1: length = t_len'(MAX_LENGTH);
                    2: length = t_len'(MAX_LENGTH + 1);
                    default: length = '1;
                endcase
            end else begin
                length = t_len'($urandom);
            end
            send_word(cmd, key, length, 1'b0, '0);
        end
        i_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (failed)
            $display("Test completed with failures");
        else
            $display("Test completed successfully");
        $finish;
    end

endmodule
